>>> rtl/signed_angle_2d_vectors_unit_assert.svh
// Assertion macros for the signed angle unit.
// Both sample on i_clk and stay quiet while i_rst_n is low.
`ifndef SIGNED_ANGLE_2D_VECTORS_UNIT_ASSERT_SVH
`define SIGNED_ANGLE_2D_VECTORS_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SA2D_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("signed angle unit: check failed");

// Consequent must hold in the cycle after the antecedent
`define SA2D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("signed angle unit: check failed");

`endif

>>> rtl/sa2d_pkg.sv
package sa2d_pkg;

    // Component width of the input vectors (Q4.12 at 16 bits)
    localparam int COMPONENT_WIDTH = 16;
    localparam int ANGLE_WIDTH     = 16;

    // Low product bits dropped so the datapath stays within 64 bits
    localparam int PROD_DROP = (2 * COMPONENT_WIDTH + 2 > 62) ?
                               (2 * COMPONENT_WIDTH + 2 - 62) : 0;
    // Product, exact sum and CORDIC x/y widths
    localparam int PROD_WIDTH = 2 * COMPONENT_WIDTH;
    localparam int SUM_WIDTH  = PROD_WIDTH + 1;
    localparam int XY_WIDTH   = PROD_WIDTH + 2 - PROD_DROP;
    // Angle accumulator, Q.30 radians with headroom past +-pi
    localparam int Z_WIDTH    = 34;
    localparam int ROUND_SHIFT = 17;

    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_MAX = 16'sd25736;

    // atan(2^-i) in units of 2^-30 rad
    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314857, 32'd497837830, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543515,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,
        32'd64,        32'd32,        32'd16,        32'd8,
        32'd4,         32'd2,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [COMPONENT_WIDTH-1:0] first_x;
        logic signed [COMPONENT_WIDTH-1:0] first_y;
        logic signed [COMPONENT_WIDTH-1:0] second_x;
        logic signed [COMPONENT_WIDTH-1:0] second_y;
    } t_sa2d_in;

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] angle;
        logic                          both_zero;
    } t_sa2d_out;

    // Degenerate-case flags that ride alongside the CORDIC datapath
    typedef struct packed {
        logic spec;   // determinant exactly zero, CORDIC result unused
        logic both;   // dot and determinant both zero
        logic pi;     // opposite direction, answer is +pi
    } t_sa2d_flag;

endpackage

>>> rtl/signed_angle_2d_vectors_unit.sv
// Channel   Valid         Ready         Data          Transfer
// input     i_in_valid    o_in_ready    i_in_data     valid & ready at rising i_clk
// output    o_out_valid   i_out_ready   o_out_data    valid & ready at rising i_clk
//
// One vector pair enters per cycle while the output is not held. Registers in order:
// products, sums, quadrant fold, one register per micro-rotation, rounding.
// Throughput is set by the unrolled CORDIC chain: one result per cycle when not stalled.
// i_rst_n is synchronous and clears only the valid bits.
// When the output is held, the whole pipeline freezes; nothing is lost.
module signed_angle_2d_vectors_unit
    import sa2d_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_sa2d_in  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_sa2d_out o_out_data
);

`include "signed_angle_2d_vectors_unit_assert.svh"

    localparam int NSTG = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

    logic en;

    // Stage P: products
    logic                         r_vld_p;
    logic signed [PROD_WIDTH-1:0] r_pxx, r_pyy, r_pxy, r_pyx;

    // Stage S: dot and determinant
    logic                       r_vld_s;
    logic signed [XY_WIDTH-1:0] r_dot, r_det;
    t_sa2d_flag                 r_flg_s;

    // CORDIC chain, index 0 is the quadrant-folded vector
    logic                       r_vld_c [NSTG+1];
    logic signed [XY_WIDTH-1:0] r_x [NSTG+1];
    logic signed [XY_WIDTH-1:0] r_y [NSTG+1];
    logic signed [Z_WIDTH-1:0]  r_z [NSTG+1];
    t_sa2d_flag                 r_flg [NSTG+1];

    // Output register
    logic      r_out_valid;
    t_sa2d_out r_out;

    logic signed [SUM_WIDTH-1:0]   dot_exact;
    logic                          det_zero, dot_zero, dot_pos;
    logic signed [Z_WIDTH:0]       z_rnd;
    logic signed [Z_WIDTH:0]       ang_full;
    logic signed [ANGLE_WIDTH-1:0] n_angle;

    // Advance every stage when the output slot is free or being taken
    assign en          = !r_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Form the four products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pxx <= PROD_WIDTH'($signed(i_in_data.first_x) * $signed(i_in_data.second_x));
            r_pyy <= PROD_WIDTH'($signed(i_in_data.first_y) * $signed(i_in_data.second_y));
            r_pxy <= PROD_WIDTH'($signed(i_in_data.first_x) * $signed(i_in_data.second_y));
            r_pyx <= PROD_WIDTH'($signed(i_in_data.first_y) * $signed(i_in_data.second_x));
        end
    end

    // Exact tests on the full products
    assign dot_exact = $signed({r_pxx[PROD_WIDTH-1], r_pxx})
                     + $signed({r_pyy[PROD_WIDTH-1], r_pyy});
    assign det_zero  = (r_pxy == r_pyx);
    assign dot_zero  = (dot_exact == '0);
    assign dot_pos   = !dot_exact[SUM_WIDTH-1] && !dot_zero;

    // Combine products into dot and determinant
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dot <= XY_WIDTH'(r_pxx >>> PROD_DROP) + XY_WIDTH'(r_pyy >>> PROD_DROP);
            r_det <= XY_WIDTH'(r_pxy >>> PROD_DROP) - XY_WIDTH'(r_pyx >>> PROD_DROP);
            r_flg_s.spec <= det_zero;
            r_flg_s.both <= det_zero && dot_zero;
            r_flg_s.pi   <= det_zero && !dot_zero && !dot_pos;
        end
    end

    // Fold the left half-plane onto the right one
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_flg[0] <= r_flg_s;
            if (!r_dot[XY_WIDTH-1]) begin
                r_x[0] <= r_dot;
                r_y[0] <= r_det;
                r_z[0] <= '0;
            end else if (!r_det[XY_WIDTH-1]) begin
                r_x[0] <= r_det;
                r_y[0] <= -r_dot;
                r_z[0] <= $signed(Z_WIDTH'(HALF_PI_Q30));
            end else begin
                r_x[0] <= -r_det;
                r_y[0] <= r_dot;
                r_z[0] <= -$signed(Z_WIDTH'(HALF_PI_Q30));
            end
        end
    end

    // Micro-rotations, one register each
    for (genvar k = 0; k < NSTG; k++) begin : g_cordic
        logic signed [XY_WIDTH-1:0] xs, ys;
        logic signed [Z_WIDTH-1:0]  step;

        assign xs   = r_x[k] >>> k;
        assign ys   = r_y[k] >>> k;
        assign step = $signed(Z_WIDTH'(ATAN_Q30[k]));

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_flg[k+1] <= r_flg[k];
                if (!r_y[k][XY_WIDTH-1]) begin
                    r_x[k+1] <= r_x[k] + ys;
                    r_y[k+1] <= r_y[k] - xs;
                    r_z[k+1] <= r_z[k] + step;
                end else begin
                    r_x[k+1] <= r_x[k] - ys;
                    r_y[k+1] <= r_y[k] + xs;
                    r_z[k+1] <= r_z[k] - step;
                end
            end
        end
    end

    // Round Q.30 to Q3.13 with ties up, then clamp to +-pi
    assign z_rnd    = $signed({r_z[NSTG][Z_WIDTH-1], r_z[NSTG]})
                    + $signed((Z_WIDTH+1)'(1 << (ROUND_SHIFT - 1)));
    assign ang_full = z_rnd >>> ROUND_SHIFT;

    always_comb begin
        if (r_flg[NSTG].spec) begin
            n_angle = r_flg[NSTG].pi ? ANGLE_MAX : '0;
        end else if (ang_full > $signed((Z_WIDTH+1)'(ANGLE_MAX))) begin
            n_angle = ANGLE_MAX;
        end else if (ang_full < -$signed((Z_WIDTH+1)'(ANGLE_MAX))) begin
            n_angle = -ANGLE_MAX;
        end else begin
            n_angle = ang_full[ANGLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.angle     <= n_angle;
            r_out.both_zero <= r_flg[NSTG].both;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_p     <= 1'b0;
            r_vld_s     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int j = 0; j <= NSTG; j++) begin
                r_vld_c[j] <= 1'b0;
            end
        end else if (en) begin
            r_vld_p    <= i_in_valid;
            r_vld_s    <= r_vld_p;
            r_vld_c[0] <= r_vld_s;
            for (int j = 0; j < NSTG; j++) begin
                r_vld_c[j+1] <= r_vld_c[j];
            end
            r_out_valid <= r_vld_c[NSTG];
        end
    end

    // Checks
    `SA2D_ASSERT_NOW(a_zero_angle_flag, o_out_valid && o_out_data.both_zero, o_out_data.angle == '0)
    `SA2D_ASSERT_NOW(a_angle_range, o_out_valid, (o_out_data.angle <= ANGLE_MAX) && (o_out_data.angle >= -ANGLE_MAX))
    `SA2D_ASSERT_NOW(a_ready_when_empty, !o_out_valid, o_in_ready)
    `SA2D_ASSERT_NEXT(a_stall_freezes, !o_in_ready, $stable(r_vld_p) && $stable(r_vld_s) && $stable(r_vld_c[NSTG]))

endmodule
